// File: hdl/pfse_pkg.sv
package pfse_pkg;

  typedef struct packed {
    logic [7:0]  fmt_byte;
    logic        fmt_last;
    logic [63:0] arg_value;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        has_char;
    logic        run_last;
    logic        format_done;
    logic [30:0] char_count;
  } out_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] value;
  } bcd_req_t;

  typedef struct packed {
    logic        done;
    logic [39:0] digits;
  } bcd_rsp_t;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_LX    = 8'h78;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'h0, nib};
    end else if (upper) begin
      r = 8'h37 + {4'h0, nib};
    end else begin
      r = 8'h57 + {4'h0, nib};
    end
    return r;
  endfunction

endpackage

// File: hdl/printf_format_stream_engine.sv
// A text byte goes to S_EMIT, then to the output register once that can load.
// %d/%i/%u: binary-to-BCD conversion, then leading zero digits are skipped
// (one digit is kept), then characters are emitted; %x/%X/%p skip zeros the
// same way, then emit. Throughput: one item at a time, up to 18 characters
// each, one output character per cycle while out_ready does not stall it.
// Reset (rst_n, synchronous, active low) clears parse mode, count and valids.
module printf_format_stream_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfse_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pfse_pkg::out_rsp_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BCD  = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_MARK = 3'd4;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_PCT   = 2'd1;
  localparam logic [1:0] MODE_SPACE = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_CHAR = 2'd1;
  localparam logic [1:0] ACT_DEC  = 2'd2;
  localparam logic [1:0] ACT_HEX  = 2'd3;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [30:0] count_r, count_nxt;
  logic        last_r, last_nxt;
  logic [15:0] pre_buf_r, pre_buf_nxt;
  logic [1:0]  pre_cnt_r, pre_cnt_nxt;
  logic [63:0] dig_r, dig_nxt;
  logic [4:0]  dig_n_r, dig_n_nxt;
  logic        upper_r, upper_nxt;
  logic        out_valid_r, out_valid_nxt;
  pfse_pkg::out_rsp_t out_data_r, out_data_nxt;

  pfse_pkg::bcd_req_t bcd_req;
  pfse_pkg::bcd_rsp_t bcd_rsp;

  logic [7:0]  c_w;
  logic        last_w;
  logic [31:0] lo_w;
  logic [31:0] mag_w;
  logic        loadable;
  logic [30:0] count_inc;
  logic        fin;
  logic [7:0]  emit_ch;

  assign c_w       = in_data.fmt_byte;
  assign last_w    = in_data.fmt_last;
  assign lo_w      = in_data.arg_value[31:0];
  assign mag_w     = lo_w[31] ? (32'h0 - lo_w) : lo_w;
  assign loadable  = !out_valid_r || out_ready;
  assign count_inc = (count_r == 31'h7FFF_FFFF) ? count_r : count_r + 31'd1;
  assign fin       = (pre_cnt_r == 2'd1 && dig_n_r == 5'd0) ||
                     (pre_cnt_r == 2'd0 && dig_n_r == 5'd1);
  assign emit_ch   = (pre_cnt_r != 2'd0) ? pre_buf_r[15:8]
                                         : pfse_pkg::hex_char(dig_r[63:60], upper_r);

  pfse_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bcd_req),
    .rsp   (bcd_rsp)
  );

  always_comb begin
    logic [1:0] act;
    logic [1:0] mode_new;
    logic       conv;
    logic [7:0] ch;
    act           = ACT_NONE;
    mode_new      = MODE_PLAIN;
    conv          = 1'b0;
    ch            = 8'h00;
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    pre_buf_nxt   = pre_buf_r;
    pre_cnt_nxt   = pre_cnt_r;
    dig_nxt       = dig_r;
    dig_n_nxt     = dig_n_r;
    upper_nxt     = upper_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    bcd_req.start = 1'b0;
    bcd_req.value = (c_w == pfse_pkg::CH_U) ? lo_w : mag_w;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (mode_r)
            MODE_PCT: begin
              if (c_w == pfse_pkg::CH_SP && !last_w) begin
                act      = ACT_CHAR;
                ch       = pfse_pkg::CH_SP;
                mode_new = MODE_SPACE;
              end else if (c_w != pfse_pkg::CH_SP) begin
                conv = 1'b1;
              end
            end
            MODE_SPACE: begin
              conv = 1'b1;
            end
            default: begin
              if (c_w == pfse_pkg::CH_PCT && !last_w) begin
                mode_new = MODE_PCT;
              end else begin
                act = ACT_CHAR;
                ch  = c_w;
              end
            end
          endcase
          pre_cnt_nxt = 2'd0;
          dig_n_nxt   = 5'd0;
          upper_nxt   = 1'b0;
          if (conv) begin
            case (c_w)
              pfse_pkg::CH_PCT: begin
                act = ACT_CHAR;
                ch  = pfse_pkg::CH_PCT;
              end
              pfse_pkg::CH_C: begin
                act = ACT_CHAR;
                ch  = in_data.arg_value[7:0];
              end
              pfse_pkg::CH_D, pfse_pkg::CH_I: begin
                act = ACT_DEC;
                if (lo_w[31]) begin
                  pre_buf_nxt = {pfse_pkg::CH_MINUS, 8'h00};
                  pre_cnt_nxt = 2'd1;
                end
              end
              pfse_pkg::CH_U: begin
                act = ACT_DEC;
              end
              pfse_pkg::CH_LX, pfse_pkg::CH_UX: begin
                act       = ACT_HEX;
                dig_nxt   = {lo_w, 32'h0};
                dig_n_nxt = 5'd8;
                upper_nxt = (c_w == pfse_pkg::CH_UX);
              end
              pfse_pkg::CH_P: begin
                act         = ACT_HEX;
                dig_nxt     = in_data.arg_value;
                dig_n_nxt   = 5'd16;
                pre_buf_nxt = {pfse_pkg::CH_ZERO, pfse_pkg::CH_LX};
                pre_cnt_nxt = 2'd2;
              end
              default: begin
                act = ACT_NONE;
              end
            endcase
          end
          if (act == ACT_CHAR) begin
            pre_buf_nxt = {ch, 8'h00};
            pre_cnt_nxt = 2'd1;
          end
          mode_nxt = last_w ? MODE_PLAIN : mode_new;
          last_nxt = last_w;
          case (act)
            ACT_CHAR: state_nxt = S_EMIT;
            ACT_DEC: begin
              state_nxt     = S_BCD;
              bcd_req.start = 1'b1;
            end
            ACT_HEX: state_nxt = S_SKIP;
            default: state_nxt = last_w ? S_MARK : S_IDLE;
          endcase
        end
      end
      S_BCD: begin
        if (bcd_rsp.done) begin
          dig_nxt   = {bcd_rsp.digits, 24'h0};
          dig_n_nxt = 5'd10;
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (dig_n_r > 5'd1 && dig_r[63:60] == 4'h0) begin
          dig_nxt   = {dig_r[59:0], 4'h0};
          dig_n_nxt = dig_n_r - 5'd1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (loadable) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_char    = emit_ch;
          out_data_nxt.has_char    = 1'b1;
          out_data_nxt.run_last    = fin;
          out_data_nxt.format_done = fin && last_r;
          out_data_nxt.char_count  = count_inc;
          count_nxt                = (fin && last_r) ? 31'd0 : count_inc;
          if (pre_cnt_r != 2'd0) begin
            pre_buf_nxt = {pre_buf_r[7:0], 8'h00};
            pre_cnt_nxt = pre_cnt_r - 2'd1;
          end else begin
            dig_nxt   = {dig_r[59:0], 4'h0};
            dig_n_nxt = dig_n_r - 5'd1;
          end
          if (fin) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MARK: begin
        if (loadable) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_char    = 8'h00;
          out_data_nxt.has_char    = 1'b0;
          out_data_nxt.run_last    = 1'b1;
          out_data_nxt.format_done = 1'b1;
          out_data_nxt.char_count  = count_r;
          count_nxt                = 31'd0;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_PLAIN;
      count_r     <= 31'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r     <= last_nxt;
    pre_buf_r  <= pre_buf_nxt;
    pre_cnt_r  <= pre_cnt_nxt;
    dig_r      <= dig_nxt;
    dig_n_r    <= dig_n_nxt;
    upper_r    <= upper_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_skip_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SKIP |-> dig_n_r != 5'd0)
    else $error("skip state with no digits");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> (pre_cnt_r != 2'd0 || dig_n_r != 5'd0))
    else $error("emit state with nothing to send");

  a_bcd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_rsp.done |-> state_r == S_BCD)
    else $error("decimal conversion finished outside its state");

  a_done_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.format_done |-> out_data_r.run_last)
    else $error("format end without request end");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.has_char |->
      out_data_r.out_char == 8'h00 && out_data_r.format_done)
    else $error("malformed marker request");
`endif

endmodule

// File: hdl/pfse_bcd.sv
module pfse_bcd (
  input  logic               clk,
  input  logic               rst_n,
  input  pfse_pkg::bcd_req_t req,
  output pfse_pkg::bcd_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] sh_r, sh_nxt;
  logic [39:0] bcd_r, bcd_nxt;
  logic [39:0] adj;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      sh_nxt   = req.value;
      bcd_nxt  = 40'h0;
    end else if (busy_r) begin
      bcd_nxt = {adj[38:0], sh_r[31]};
      sh_nxt  = {sh_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.digits = bcd_r;

endmodule
